>>> rtl/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg: shared constants, types and tables for the perspective row remap
// Holds the Q16 format constants, register indexes and the log2/exp2
// interpolation tables, which are built at elaboration.
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LOG_N     = 256;
    localparam int MANT_BITS = 30;
    localparam int LOG_BITS  = 20;

    // width of an exponent product after the Q16 shift
    localparam int Q_W       = 41;
    // quotient bits and divisor width of the pipelined dividers
    localparam int DIV_QW    = 32;
    localparam int DIV_DW    = 17;

    localparam logic [16:0] ONE      = 17'h10000;
    localparam logic [15:0] EASE_EXP = 16'((9 << FRAC_BITS) / 10);

    localparam logic [63:0] MANT_ONE = 64'd1 << MANT_BITS;

    typedef enum logic [1:0] {
        REG_HORIZON = 2'd0,
        REG_ANCHOR  = 2'd1,
        REG_TOP     = 2'd2,
        REG_BOTTOM  = 2'd3
    } reg_idx_t;

    typedef logic [20:0] log_tab_t [0:LOG_N];
    typedef logic [31:0] exp_tab_t [0:LOG_N];

    function automatic log_tab_t build_log_tab();
        log_tab_t    tab;
        logic [63:0] m;
        logic [63:0] frac;
        for (int i = 0; i < LOG_N; i++)
        begin
            m    = MANT_ONE + ((64'(i) << MANT_BITS) / LOG_N);
            frac = 64'd0;
            for (int b = 0; b < LOG_BITS; b++)
            begin
                m    = (m * m) >> MANT_BITS;
                frac = frac << 1;
                if (m >= 2 * MANT_ONE)
                begin
                    m    = m >> 1;
                    frac = frac | 64'd1;
                end
            end
            tab[i] = 21'(frac);
        end
        tab[LOG_N] = 21'(64'd1 << LOG_BITS);
        return tab;
    endfunction

    // truncated power r^LOG_N in Q30, zero once it passes 2.0
    function automatic logic [63:0] pow_check(input logic [63:0] r);
        logic [63:0] acc;
        logic        over;
        acc  = MANT_ONE;
        over = 1'b0;
        for (int i = 0; i < LOG_N; i++)
        begin
            if (!over)
            begin
                acc = (acc * r) >> MANT_BITS;
                if (acc > 2 * MANT_ONE)
                    over = 1'b1;
            end
        end
        return over ? 64'd0 : acc;
    endfunction

    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] acc;
        lo = MANT_ONE;
        hi = 2 * MANT_ONE;
        while (hi - lo > 64'd1)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (pow_check(mid) != 64'd0)
                lo = mid;
            else
                hi = mid;
        end
        acc    = MANT_ONE;
        tab[0] = 32'(acc);
        for (int i = 1; i <= LOG_N; i++)
        begin
            acc    = (acc * lo) >> MANT_BITS;
            tab[i] = 32'(acc);
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TAB = build_log_tab();
    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

>>> rtl/prr_div.sv
// ----------------------------------------------------------------------------
// prr_div: pipelined restoring divider
// One quotient bit per stage; the numerator bits shift out while the
// quotient bits shift in. The divisor must hold steady while items are in
// flight.
// ----------------------------------------------------------------------------
module prr_div #(
    parameter int QW = 32,
    parameter int DW = 17
) (
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] bits_in,
    input  logic [DW-1:0] divisor,
    output logic [QW-1:0] quo
);

    logic [DW-1:0] rem_reg  [0:QW-1];
    logic [QW-1:0] bits_reg [0:QW-1];
    logic [DW-1:0] rem_next [0:QW-1];
    logic [QW-1:0] bits_next[0:QW-1];

    always_comb
    begin
        logic [DW:0]   trial;
        logic [DW-1:0] r;
        logic [QW-1:0] b;
        for (int s = 0; s < QW; s++)
        begin
            r     = (s == 0) ? rem_in  : rem_reg[s-1];
            b     = (s == 0) ? bits_in : bits_reg[s-1];
            trial = {r, b[QW-1]};
            if (trial >= {1'b0, divisor})
            begin
                rem_next[s]  = DW'(trial - {1'b0, divisor});
                bits_next[s] = {b[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = trial[DW-1:0];
                bits_next[s] = {b[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < QW; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                bits_reg[s] <= bits_next[s];
            end
        end
    end

    assign quo = bits_reg[QW-1];

endmodule

>>> rtl/prr_exp2.sv
// ----------------------------------------------------------------------------
// prr_exp2: four-stage 2^(-q) unit
// q is Q20; the result is Q16. The fraction is interpolated from the exp2
// table and the integer part becomes a right shift.
// ----------------------------------------------------------------------------
module prr_exp2 (
    input  logic                   clk,
    input  logic                   en,
    input  logic [prr_pkg::Q_W-1:0] q,
    input  logic                   zero,
    output logic [17:0]            p
);

    logic [21:0] x1_k_reg;
    logic [19:0] x1_f_reg;
    logic        x1_zero_reg;
    logic [21:0] x2_k_reg;
    logic [31:0] x2_base_reg;
    logic [31:0] x2_diff_reg;
    logic [11:0] x2_low_reg;
    logic        x2_zero_reg;
    logic [21:0] x3_k_reg;
    logic [31:0] x3_base_reg;
    logic [43:0] x3_prod_reg;
    logic        x3_zero_reg;
    logic [17:0] p_reg;

    logic [21:0] k_next;
    logic [19:0] f_next;
    logic [8:0]  idx;
    logic [31:0] base_next;
    logic [31:0] diff_next;
    logic [32:0] m;
    logic [22:0] sh;
    logic [17:0] p_next;

    always_comb
    begin
        // ceiling of q in whole units, and the fraction that is left over
        k_next    = 22'(q[prr_pkg::Q_W-1:20]) + 22'(q[19:0] != 20'd0);
        f_next    = 20'(21'h100000 - 21'(q[19:0]));
        idx       = {1'b0, x1_f_reg[19:12]};
        base_next = prr_pkg::EXP_TAB[idx];
        diff_next = prr_pkg::EXP_TAB[idx + 9'd1] - base_next;
        m         = 33'(x3_base_reg) + 33'(x3_prod_reg[43:12]);
        sh        = 23'(x3_k_reg) + 23'(prr_pkg::MANT_BITS - prr_pkg::FRAC_BITS);
        if (x3_zero_reg || sh >= 23'd63)
            p_next = 18'd0;
        else
            p_next = 18'(m >> sh[5:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_k_reg    <= k_next;
            x1_f_reg    <= f_next;
            x1_zero_reg <= zero;
            x2_k_reg    <= x1_k_reg;
            x2_base_reg <= base_next;
            x2_diff_reg <= diff_next;
            x2_low_reg  <= x1_f_reg[11:0];
            x2_zero_reg <= x1_zero_reg;
            x3_k_reg    <= x2_k_reg;
            x3_base_reg <= x2_base_reg;
            x3_prod_reg <= 44'(x2_diff_reg) * 44'(x2_low_reg);
            x3_zero_reg <= x2_zero_reg;
            p_reg       <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/perspective_row_remap_top.sv
// ----------------------------------------------------------------------------
// perspective_row_remap_top: perspective row remap pipeline
// Maps a source row fraction to a remapped row and a width scale.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid/in_ready, source_row) takes one row item per cycle while in_ready is high.
//   out channel (out_valid/out_ready, mapped_row, width_factor, settings_ok)
//   gives one result item for each input item, in order.
//   The user must write the registers over the APB port only while no item is in flight;
//   the block does not enforce this. Addresses: horizon_ratio at 0x0, anchor_ratio at 0x4,
//   top_width at 0x8, bottom_width at 0xC. pready is always high.
// Pipeline: the three 32-stage dividers feed the log2, exponent, exp2 and blend
//   stages, which lead to the output register and out_valid.
// Throughput: one item per cycle while out_ready stays high.
// Stall: when out_ready is low the result waits in the output register and
//   one more item lands in a skid register; only then does in_ready drop and
//   the whole pipeline hold.
// Reset: rst_n clears all valid bits and loads the default register values;
//   the block takes items from the first cycle after reset.
// ----------------------------------------------------------------------------
module perspective_row_remap_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [17:0] source_row,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [16:0]        mapped_row,
    output logic [17:0]        width_factor,
    output logic               settings_ok
);

    localparam int DIV_LAT = prr_pkg::DIV_QW;
    localparam int N_STG   = DIV_LAT + 11;
    localparam int S_F2    = N_STG - 1;

    // configuration
    logic [15:0] horizon_reg;
    logic [15:0] anchor_reg;
    logic [17:0] top_reg;
    logic [17:0] bottom_reg;
    logic        cfg_wr;
    logic        cfg_ok;
    logic [15:0] span;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            horizon_reg <= 16'd6554;
            anchor_reg  <= 16'd44564;
            top_reg     <= 18'd39322;
            bottom_reg  <= 18'd70779;
        end
        else if (cfg_wr)
        begin
            unique case (prr_pkg::reg_idx_t'(paddr[3:2]))
                prr_pkg::REG_HORIZON: horizon_reg <= pwdata[15:0];
                prr_pkg::REG_ANCHOR:  anchor_reg  <= pwdata[15:0];
                prr_pkg::REG_TOP:     top_reg     <= pwdata[17:0];
                prr_pkg::REG_BOTTOM:  bottom_reg  <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (prr_pkg::reg_idx_t'(paddr[3:2]))
            prr_pkg::REG_HORIZON: prdata = 32'(horizon_reg);
            prr_pkg::REG_ANCHOR:  prdata = 32'(anchor_reg);
            prr_pkg::REG_TOP:     prdata = 32'(top_reg);
            prr_pkg::REG_BOTTOM:  prdata = 32'(bottom_reg);
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg_ok = (horizon_reg < anchor_reg) && (anchor_reg != 16'd0) &&
                    (top_reg != 18'd0) && (bottom_reg != 18'd0);
    assign span   = anchor_reg - horizon_reg;

    // pipeline control
    logic             en;
    logic [N_STG-1:0] v_reg;
    logic [16:0]      src_reg [0:N_STG-1];
    logic             skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[N_STG-2:0], in_valid};
    end

    // input clamp to 0..1.0
    logic [16:0] src_in;
    logic [16:0] d2_in;

    always_comb
    begin
        if (source_row[17])
            src_in = 17'd0;
        else if (source_row > 18'sd65536)
            src_in = prr_pkg::ONE;
        else
            src_in = source_row[16:0];
        d2_in = src_in - 17'(anchor_reg);
    end

    // dividers: src/anchor, anchor/span, (src-anchor)/(1-anchor)
    logic [31:0] x_quo;
    logic [31:0] e_quo;
    logic [31:0] t2_quo;

    prr_div #(.QW(prr_pkg::DIV_QW), .DW(prr_pkg::DIV_DW)) u_div_x (
        .clk     (clk),
        .en      (en),
        .rem_in  (17'(src_in[16])),
        .bits_in ({src_in[15:0], 16'd0}),
        .divisor (17'(anchor_reg)),
        .quo     (x_quo)
    );

    prr_div #(.QW(prr_pkg::DIV_QW), .DW(prr_pkg::DIV_DW)) u_div_e (
        .clk     (clk),
        .en      (en),
        .rem_in  (17'd0),
        .bits_in ({anchor_reg, 16'd0}),
        .divisor (17'(span)),
        .quo     (e_quo)
    );

    prr_div #(.QW(prr_pkg::DIV_QW), .DW(prr_pkg::DIV_DW)) u_div_t (
        .clk     (clk),
        .en      (en),
        .rem_in  (17'(d2_in[16])),
        .bits_in ({d2_in[15:0], 16'd0}),
        .divisor (prr_pkg::ONE - 17'(anchor_reg)),
        .quo     (t2_quo)
    );

    // log2 stages
    logic [4:0]  l1_p_reg;
    logic [29:0] l1_t_reg;
    logic [20:0] l2_base_reg;
    logic [20:0] l2_diff_reg;
    logic [21:0] l2_low_reg;
    logic [4:0]  l2_p_reg;
    logic [42:0] l3_prod_reg;
    logic [20:0] l3_base_reg;
    logic [4:0]  l3_p_reg;
    logic [24:0] nl_reg;
    logic [40:0] qm_reg;
    logic [40:0] qw_reg;
    logic        m1_zero_reg;
    logic [31:0] e_d   [0:3];
    logic        zero_d[0:3];
    logic [16:0] t2_d  [0:8];

    logic [16:0] x;
    logic [4:0]  p_next;
    logic [30:0] mant;
    logic [8:0]  lidx;
    logic [20:0] lbase;
    logic [20:0] ldiff;
    logic [21:0] frac;
    logic [24:0] nl_next;
    logic [56:0] qm_prod;
    logic [56:0] qw_prod;

    always_comb
    begin
        x      = x_quo[16:0];
        p_next = 5'd0;
        for (int i = 1; i < 17; i++)
        begin
            if (x[i])
                p_next = 5'(i);
        end
        mant    = 31'(x) << (5'(prr_pkg::MANT_BITS) - p_next);
        lidx    = {1'b0, l1_t_reg[29:22]};
        lbase   = prr_pkg::LOG_TAB[lidx];
        ldiff   = prr_pkg::LOG_TAB[lidx + 9'd1] - lbase;
        frac    = 22'(l3_base_reg) + 22'(l3_prod_reg[42:22]);
        nl_next = 25'({5'(prr_pkg::FRAC_BITS) - l3_p_reg, 20'd0}) - 25'(frac);
        qm_prod = 57'(e_d[3]) * 57'(nl_reg);
        qw_prod = 57'(prr_pkg::EASE_EXP) * 57'(nl_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            src_reg[0] <= src_in;
            for (int i = 1; i < N_STG; i++)
                src_reg[i] <= src_reg[i-1];

            l1_p_reg    <= p_next;
            l1_t_reg    <= mant[29:0];
            e_d[0]      <= e_quo;
            zero_d[0]   <= (x == 17'd0);
            t2_d[0]     <= t2_quo[16:0];
            for (int i = 1; i < 4; i++)
            begin
                e_d[i]    <= e_d[i-1];
                zero_d[i] <= zero_d[i-1];
            end
            for (int i = 1; i < 9; i++)
                t2_d[i] <= t2_d[i-1];

            l2_base_reg <= lbase;
            l2_diff_reg <= ldiff;
            l2_low_reg  <= l1_t_reg[21:0];
            l2_p_reg    <= l1_p_reg;
            l3_prod_reg <= 43'(l2_diff_reg) * 43'(l2_low_reg);
            l3_base_reg <= l2_base_reg;
            l3_p_reg    <= l2_p_reg;
            nl_reg      <= nl_next;
            qm_reg      <= qm_prod[56:16];
            qw_reg      <= qw_prod[56:16];
            m1_zero_reg <= zero_d[3];
        end
    end

    // exp2 for the horizon curve and for the width easing
    logic [17:0] pm;
    logic [17:0] pw;

    prr_exp2 u_exp_map (
        .clk  (clk),
        .en   (en),
        .q    (qm_reg),
        .zero (m1_zero_reg),
        .p    (pm)
    );

    prr_exp2 u_exp_wid (
        .clk  (clk),
        .en   (en),
        .q    (qw_reg),
        .zero (m1_zero_reg),
        .p    (pw)
    );

    // blend stages
    logic [33:0] f1_pm_reg;
    logic [34:0] f1_wa_reg;
    logic [34:0] f1_wb_reg;
    logic [17:0] f1_pw_reg;
    logic [16:0] f1_t2_reg;
    logic [16:0] f2_mapped_reg;
    logic [17:0] f2_width_reg;
    logic        f2_ok_reg;

    logic [16:0] src_f;
    logic [16:0] mapped_curve;
    logic [35:0] above_sum;
    logic [35:0] below_sum;
    logic [16:0] mapped_next;
    logic [17:0] width_next;

    always_comb
    begin
        src_f        = src_reg[S_F2-1];
        mapped_curve = 17'(horizon_reg) + 17'((35'(f1_pm_reg) + 35'd32768) >> 16);
        above_sum    = 36'(f1_wa_reg) + (36'(f1_pw_reg) << 16) + 36'd32768;
        below_sum    = (36'(prr_pkg::ONE - f1_t2_reg) << 16) + 36'(f1_wb_reg) + 36'd32768;
        if (!cfg_ok)
        begin
            mapped_next = src_f;
            width_next  = 18'(prr_pkg::ONE);
        end
        else
        begin
            mapped_next = (src_f >= 17'(anchor_reg)) ? src_f : mapped_curve;
            width_next  = (src_f <= 17'(anchor_reg)) ? above_sum[33:16] : below_sum[33:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_pm_reg     <= 34'(span) * 34'(pm);
            f1_wa_reg     <= 35'(top_reg) * 35'(18'(prr_pkg::ONE) - pw);
            f1_wb_reg     <= 35'(bottom_reg) * 35'(t2_d[8]);
            f1_pw_reg     <= pw;
            f1_t2_reg     <= t2_d[8];
            f2_mapped_reg <= mapped_next;
            f2_width_reg  <= width_next;
            f2_ok_reg     <= cfg_ok;
        end
    end

    // output register with skid
    logic        out_valid_reg;
    logic [16:0] out_mapped_reg;
    logic [17:0] out_width_reg;
    logic        out_ok_reg;
    logic [16:0] skid_mapped_reg;
    logic [17:0] skid_width_reg;
    logic        skid_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
                skid_valid_reg <= 1'b0;
        end
        else if (v_reg[S_F2])
        begin
            if (!out_valid_reg || out_ready)
                out_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_mapped_reg <= skid_mapped_reg;
                out_width_reg  <= skid_width_reg;
                out_ok_reg     <= skid_ok_reg;
            end
        end
        else if (v_reg[S_F2])
        begin
            if (!out_valid_reg || out_ready)
            begin
                out_mapped_reg <= f2_mapped_reg;
                out_width_reg  <= f2_width_reg;
                out_ok_reg     <= f2_ok_reg;
            end
            else
            begin
                skid_mapped_reg <= f2_mapped_reg;
                skid_width_reg  <= f2_width_reg;
                skid_ok_reg     <= f2_ok_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign mapped_row   = out_mapped_reg;
    assign width_factor = out_width_reg;
    assign settings_ok  = out_ok_reg;

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for perspective_row_remap_top
// Drives row items through valid/ready with random gaps and stalls, writes
// the four configuration registers over APB between phases, and compares every
// result item against a bit-exact fixed-point remap predictor.
// ----------------------------------------------------------------------------
module tb;

    typedef struct packed {
        logic [16:0] row;
        logic [17:0] width;
        logic        ok;
    } remap_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [17:0] source_row;
    logic               out_valid;
    logic               out_ready;
    logic [16:0]        mapped_row;
    logic [17:0]        width_factor;
    logic               settings_ok;

    perspective_row_remap_top uut (.*);

    logic [63:0] lg_tab [0:256];
    logic [63:0] ex_tab [0:256];
    logic [63:0] horizon, anchor, top_w, bottom_w;

    logic [17:0] rows_to_send [$];
    remap_t      remap_due [$];
    int          errors;
    bit          row_taken;
    bit          steady;
    bit          hold_req;
    int          hold_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [63:0] mant_pow(input logic [63:0] r);
        logic [63:0] acc;
        acc = 64'd1 << 30;
        for (int i = 0; i < 256; i++)
        begin
            acc = (acc * r) >> 30;
            if (acc > (64'd2 << 30))
                return 64'd0;
        end
        return acc;
    endfunction

    task automatic fill_tables();
        logic [63:0] m, fr, lo, hi, mid;
        for (int i = 0; i < 256; i++)
        begin
            m  = (64'd1 << 30) + ((64'(i) << 30) / 256);
            fr = 0;
            for (int b = 0; b < 20; b++)
            begin
                m  = (m * m) >> 30;
                fr = fr << 1;
                if (m >= (64'd2 << 30))
                begin
                    m  = m >> 1;
                    fr = fr | 1;
                end
            end
            lg_tab[i] = fr;
        end
        lg_tab[256] = 64'd1 << 20;
        lo = 64'd1 << 30;
        hi = 64'd2 << 30;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (mant_pow(mid) != 0)
                lo = mid;
            else
                hi = mid;
        end
        ex_tab[0] = 64'd1 << 30;
        for (int i = 1; i <= 256; i++)
            ex_tab[i] = (ex_tab[i - 1] * lo) >> 30;
    endtask

    // -log2(x) in Q20 for 0 < x <= 1.0
    function automatic logic [63:0] neg_log(input logic [63:0] x);
        logic [63:0] p, mant, t, idx, rem, fr;
        p = 0;
        while (p < 63 && (x >> (p + 1)) != 0)
            p++;
        mant = x << (30 - p);
        t    = mant - (64'd1 << 30);
        idx  = (t * 256) >> 30;
        if (idx >= 256)
            idx = 255;
        rem = t * 256 - (idx << 30);
        fr  = lg_tab[idx] + (((lg_tab[idx + 1] - lg_tab[idx]) * rem) >> 30);
        return ((64'd16 - p) << 20) - fr;
    endfunction

    function automatic logic [63:0] exp_neg(input logic [63:0] q);
        logic [63:0] k, f, idx, rem, m, sh;
        k   = (q + (64'd1 << 20) - 1) >> 20;
        f   = (k << 20) - q;
        idx = (f * 256) >> 20;
        if (idx >= 256)
            idx = 255;
        rem = f * 256 - (idx << 20);
        m   = ex_tab[idx] + (((ex_tab[idx + 1] - ex_tab[idx]) * rem) >> 20);
        sh  = 14 + k;
        if (sh >= 63)
            return 64'd0;
        return m >> sh;
    endfunction

    function automatic logic [63:0] q16_pow(input logic [63:0] x, input logic [63:0] e);
        if (x == 0)
            return 64'd0;
        return exp_neg((e * neg_log(x)) >> 16);
    endfunction

    function automatic remap_t remap_row(input logic [17:0] raw);
        logic [63:0] src, span, e, t, row, wid;
        logic        ok;
        remap_t      r;
        if (raw[17])
            src = 0;
        else if (raw > 18'h10000)
            src = 64'h10000;
        else
            src = 64'(raw);
        ok = horizon < anchor && anchor > 0 && anchor < 64'h10000 && top_w > 0
             && bottom_w > 0;
        if (!ok)
        begin
            row = src;
            wid = 64'h10000;
        end
        else
        begin
            if (src >= anchor)
                row = src;
            else
            begin
                span = anchor - horizon;
                e    = (anchor << 16) / span;
                t    = q16_pow((src << 16) / anchor, e);
                row  = horizon + ((span * t + 32768) >> 16);
            end
            if (src <= anchor)
            begin
                t   = q16_pow((src << 16) / anchor, (64'd9 << 16) / 10);
                wid = (top_w * (64'h10000 - t) + 64'h10000 * t + 32768) >> 16;
            end
            else
            begin
                t   = ((src - anchor) << 16) / (64'h10000 - anchor);
                wid = (64'h10000 * (64'h10000 - t) + bottom_w * t + 32768) >> 16;
            end
        end
        r.row   = row[16:0];
        r.width = wid[17:0];
        r.ok    = ok;
        return r;
    endfunction

    task automatic reg_write(input prr_pkg::reg_idx_t idx, input logic [17:0] val);
        logic [31:0] word;
        word = {14'($urandom), val};
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            prr_pkg::REG_HORIZON: horizon  = 64'(word[15:0]);
            prr_pkg::REG_ANCHOR:  anchor   = 64'(word[15:0]);
            prr_pkg::REG_TOP:     top_w    = 64'(word[17:0]);
            prr_pkg::REG_BOTTOM:  bottom_w = 64'(word[17:0]);
        endcase
    endtask

    task automatic set_regs(input logic [17:0] h, input logic [17:0] a,
                            input logic [17:0] tw, input logic [17:0] bw);
        reg_write(prr_pkg::REG_HORIZON, h);
        reg_write(prr_pkg::REG_ANCHOR, a);
        reg_write(prr_pkg::REG_TOP, tw);
        reg_write(prr_pkg::REG_BOTTOM, bw);
    endtask

    // nothing queued, nothing offered and nothing still expected
    task automatic drain();
        wait (rows_to_send.size() == 0 && !in_valid && remap_due.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    task automatic edge_rows();
        logic [17:0] a;
        a = anchor[17:0];
        rows_to_send.push_back(18'h0);
        rows_to_send.push_back(18'h1);
        rows_to_send.push_back(horizon[17:0]);
        rows_to_send.push_back(a - 18'd1);
        rows_to_send.push_back(a);
        rows_to_send.push_back(a + 18'd1);
        rows_to_send.push_back(18'h0FFFF);
        rows_to_send.push_back(18'h10000);
        rows_to_send.push_back(18'h10001);
        rows_to_send.push_back(18'h1FFFF);
        rows_to_send.push_back(18'h3FFFF);
        rows_to_send.push_back(18'h20000);
    endtask

    task automatic random_rows(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 8)
                rows_to_send.push_back(18'($urandom_range(65536)));
            else
                rows_to_send.push_back(18'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; source_row = 0; out_ready = 0;
        errors = 0; steady = 0; hold_req = 0; hold_left = 0;
        horizon = 6554; anchor = 44564; top_w = 39322; bottom_w = 70779;
        fill_tables();
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        edge_rows();
        random_rows(8);
        drain();

        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: set_regs(18'd0, 18'd1, 18'h3FFFF, 18'h3FFFF);
                1: set_regs(18'hFFFE, 18'hFFFF, 18'd1, 18'd1);
                2: set_regs(18'd0, 18'hFFFF, 18'h10000, 18'h10000);
                3: set_regs(18'd100, 18'd100, 18'd39322, 18'd70779); // horizon not above anchor
                4: set_regs(18'd0, 18'd0, 18'd39322, 18'd70779);
                5: set_regs(18'd6554, 18'd44564, 18'd0, 18'd70779);
                6: set_regs(18'd6554, 18'd44564, 18'd39322, 18'd0);
                7: set_regs(18'hFFFF, 18'h8000, 18'd5, 18'd9);
                default: set_regs(18'($urandom_range(30000)), 18'($urandom_range(65535, 30001)),
                                  18'($urandom_range(1, 262143)),
                                  18'($urandom_range(1, 262143)));
            endcase
            edge_rows();
            steady = (ph == 8);
            if (ph == 2)
            begin
                random_rows(60);
                hold_req = 1;
            end
            random_rows(75);
            // sender waits until every result is back
            if (ph == 5)
            begin
                wait (rows_to_send.size() == 0 && !in_valid && remap_due.size() == 0);
                random_rows(20);
            end
            drain();
        end

        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || row_taken))
        begin
            if (rows_to_send.size() != 0 && (steady || $urandom_range(99) >= 7))
            begin
                in_valid   <= 1'b1;
                source_row <= rows_to_send.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 0;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && (steady || $urandom_range(99) >= 7);
    end

    // monitor
    always @(posedge clk)
    begin
        remap_t got, want;
        row_taken = in_valid && in_ready;
        if (row_taken)
            remap_due.push_back(remap_row(source_row));
        if (out_valid && out_ready)
        begin
            got = '{mapped_row, width_factor, settings_ok};
            if (remap_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item row=%0d width=%0d ok=%0d",
                             mapped_row, width_factor, settings_ok);
            end
            else
            begin
                want = remap_due.pop_front();
                if (got.row !== want.row || got.width !== want.width
                    || got.ok !== want.ok)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: row %0d/%0d width %0d/%0d ok %0d/%0d (exp/got)",
                                 want.row, got.row, want.width, got.width,
                                 want.ok, got.ok);
                end
            end
        end
    end

endmodule
